// File: rtl/delayed_digital_output_bank_macros.svh
// Assertion shorthands shared by the checker. Both sample on i_clk and are
// quiet while i_rst_n is low.
`ifndef DELAYED_DIGITAL_OUTPUT_BANK_MACROS_SVH
`define DELAYED_DIGITAL_OUTPUT_BANK_MACROS_SVH

`define DDOB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`define DDOB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ddob_pkg.sv
package ddob_pkg;

    localparam int CH_W     = 5;
    localparam int CH_CMP_W = CH_W + 1;
    localparam int TIME_W   = 32;
    localparam int BANK_W   = 32;

    localparam logic [TIME_W-1:0] PULSE_RESET = 32'd1000;

    localparam logic [3:0] OP_ON        = 4'd0;
    localparam logic [3:0] OP_OFF       = 4'd1;
    localparam logic [3:0] OP_TOGGLE    = 4'd2;
    localparam logic [3:0] OP_DLY_ON    = 4'd3;
    localparam logic [3:0] OP_DLY_OFF   = 4'd4;
    localparam logic [3:0] OP_ON_OFF    = 4'd5;
    localparam logic [3:0] OP_CANCEL    = 4'd6;
    localparam logic [3:0] OP_TRIGGER   = 4'd7;
    localparam logic [3:0] OP_ALL_OFF   = 4'd8;
    localparam logic [3:0] OP_SET_ALL   = 4'd9;
    localparam logic [3:0] OP_CHECK     = 4'd10;
    localparam logic [3:0] OP_READ      = 4'd11;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_ON    = 2'd1,
        MODE_OFF   = 2'd2,
        MODE_ONOFF = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [3:0]        opcode;
        logic [CH_W-1:0]   channel;
        logic [TIME_W-1:0] on_delay_ms;
        logic [TIME_W-1:0] off_delay_ms;
        logic [TIME_W-1:0] now_ms;
        logic [BANK_W-1:0] pattern;
    } t_in_req;

    typedef struct packed {
        logic [BANK_W-1:0] output_bits;
        logic [BANK_W-1:0] standard_bits;
        logic              channel_on;
        logic              channel_delayed;
    } t_out_req;

    typedef struct packed {
        logic capture;
        logic read;
        logic commit;
    } t_ctrl_cmd;

endpackage

// File: rtl/ddob_datapath.sv
module ddob_datapath #(
    parameter int CHANNELS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ddob_pkg::t_ctrl_cmd           i_cmd,
    input  ddob_pkg::t_in_req             i_req,
    input  logic                          i_cfg_we,
    input  logic [ddob_pkg::TIME_W-1:0]   i_cfg_wdata,
    output ddob_pkg::t_out_req            o_rsp
);

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Channel timer storage; its read values only matter in a delay mode, which
    // always writes the entries it uses first.
    logic [ddob_pkg::TIME_W-1:0] mem_start [CHANNELS];
    logic [ddob_pkg::TIME_W-1:0] mem_on    [CHANNELS];
    logic [ddob_pkg::TIME_W-1:0] mem_off   [CHANNELS];

    ddob_pkg::t_mode             r_mode [CHANNELS];
    ddob_pkg::t_mode             n_mode [CHANNELS];
    logic [CHANNELS-1:0]         r_shadow;
    logic [CHANNELS-1:0]         n_shadow;
    logic [ADDR_W-1:0]           r_ptr;
    logic [ADDR_W-1:0]           n_ptr;
    logic [ddob_pkg::TIME_W-1:0] r_pulse;

    logic [3:0]                  r_op;
    logic [ddob_pkg::CH_W-1:0]   r_ch;
    logic                        r_ch_ok;
    logic                        r_sel_ok;
    logic [ADDR_W-1:0]           r_sel;
    logic [ddob_pkg::TIME_W-1:0] r_ond;
    logic [ddob_pkg::TIME_W-1:0] r_offd;
    logic [ddob_pkg::TIME_W-1:0] r_now;
    logic [CHANNELS-1:0]         r_pat;

    ddob_pkg::t_mode             r_rd_mode;
    logic [ddob_pkg::TIME_W-1:0] r_rd_start;
    logic [ddob_pkg::TIME_W-1:0] r_rd_on;
    logic [ddob_pkg::TIME_W-1:0] r_rd_off;

    ddob_pkg::t_out_req          r_rsp;

    logic                        ch_ok_in;
    logic [ADDR_W-1:0]           sel_in;
    logic [ddob_pkg::TIME_W-1:0] elapsed;
    logic                        cur_bit;
    logic                        use_on;
    logic                        expired;
    logic                        we_start;
    logic                        we_on;
    logic                        we_off;
    logic [ddob_pkg::TIME_W-1:0] off_wdata;
    logic [CHANNELS-1:0]         active;

    assign ch_ok_in = {1'b0, i_req.channel} < ddob_pkg::CH_CMP_W'(CHANNELS);
    assign sel_in   = (i_req.opcode == ddob_pkg::OP_CHECK) ? r_ptr
                                                           : i_req.channel[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_req.opcode;
            r_ch     <= i_req.channel;
            r_ch_ok  <= ch_ok_in;
            r_sel_ok <= (i_req.opcode == ddob_pkg::OP_CHECK) || ch_ok_in;
            r_sel    <= sel_in;
            r_ond    <= i_req.on_delay_ms;
            r_offd   <= i_req.off_delay_ms;
            r_now    <= i_req.now_ms;
            r_pat    <= i_req.pattern[CHANNELS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_mode  <= r_mode[r_sel];
            r_rd_start <= mem_start[r_sel];
            r_rd_on    <= mem_on[r_sel];
            r_rd_off   <= mem_off[r_sel];
        end
        if (i_cmd.commit) begin
            if (we_start) begin
                mem_start[r_sel] <= r_now;
            end
            if (we_on) begin
                mem_on[r_sel] <= r_ond;
            end
            if (we_off) begin
                mem_off[r_sel] <= off_wdata;
            end
        end
    end

    assign elapsed   = r_now - r_rd_start;
    assign cur_bit   = r_shadow[r_sel];
    assign use_on    = (r_rd_mode == ddob_pkg::MODE_ON) ||
                       ((r_rd_mode == ddob_pkg::MODE_ONOFF) && !cur_bit);
    assign expired   = elapsed >= (use_on ? r_rd_on : r_rd_off);
    assign off_wdata = (r_op == ddob_pkg::OP_TRIGGER) ? r_pulse : r_offd;

    always_comb begin
        n_shadow = r_shadow;
        n_mode   = r_mode;
        n_ptr    = r_ptr;
        we_start = 1'b0;
        we_on    = 1'b0;
        we_off   = 1'b0;
        case (r_op)
            ddob_pkg::OP_ALL_OFF: begin
                n_shadow = '0;
            end
            ddob_pkg::OP_SET_ALL: begin
                n_shadow = r_pat;
            end
            ddob_pkg::OP_CHECK: begin
                n_ptr = (r_ptr == ADDR_W'(CHANNELS - 1)) ? '0 : r_ptr + 1'b1;
                case (r_rd_mode)
                    ddob_pkg::MODE_ON: begin
                        if (expired) begin
                            n_shadow[r_sel] = 1'b1;
                            n_mode[r_sel]   = ddob_pkg::MODE_NONE;
                        end
                    end
                    ddob_pkg::MODE_OFF: begin
                        if (expired) begin
                            n_shadow[r_sel] = 1'b0;
                            n_mode[r_sel]   = ddob_pkg::MODE_NONE;
                        end
                    end
                    ddob_pkg::MODE_ONOFF: begin
                        // The on phase restarts the clock for the off phase.
                        if (expired && !cur_bit) begin
                            n_shadow[r_sel] = 1'b1;
                            we_start        = 1'b1;
                        end else if (expired) begin
                            n_shadow[r_sel] = 1'b0;
                            n_mode[r_sel]   = ddob_pkg::MODE_NONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ddob_pkg::OP_ON: begin
                if (r_sel_ok) begin
                    n_shadow[r_sel] = 1'b1;
                end
            end
            ddob_pkg::OP_OFF: begin
                if (r_sel_ok) begin
                    n_shadow[r_sel] = 1'b0;
                end
            end
            ddob_pkg::OP_TOGGLE: begin
                if (r_sel_ok) begin
                    n_shadow[r_sel] = !cur_bit;
                end
            end
            ddob_pkg::OP_DLY_ON: begin
                if (r_sel_ok) begin
                    n_mode[r_sel] = ddob_pkg::MODE_ON;
                    we_on         = 1'b1;
                    we_start      = 1'b1;
                end
            end
            ddob_pkg::OP_DLY_OFF, ddob_pkg::OP_TRIGGER: begin
                if (r_sel_ok) begin
                    n_shadow[r_sel] = 1'b1;
                    n_mode[r_sel]   = ddob_pkg::MODE_OFF;
                    we_off          = 1'b1;
                    we_start        = 1'b1;
                end
            end
            ddob_pkg::OP_ON_OFF: begin
                if (r_sel_ok) begin
                    n_mode[r_sel] = ddob_pkg::MODE_ONOFF;
                    we_on         = 1'b1;
                    we_off        = 1'b1;
                    we_start      = 1'b1;
                end
            end
            ddob_pkg::OP_CANCEL: begin
                if (r_sel_ok) begin
                    n_mode[r_sel] = ddob_pkg::MODE_NONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            active[i] = n_mode[i] != ddob_pkg::MODE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow <= '0;
            r_ptr    <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_mode[i] <= ddob_pkg::MODE_NONE;
            end
        end else if (i_cmd.commit) begin
            r_shadow <= n_shadow;
            r_ptr    <= n_ptr;
            r_mode   <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse <= ddob_pkg::PULSE_RESET;
        end else if (i_cfg_we) begin
            r_pulse <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp.output_bits     <= ddob_pkg::BANK_W'(n_shadow);
            r_rsp.standard_bits   <= ddob_pkg::BANK_W'(n_shadow & ~active);
            r_rsp.channel_on      <= r_ch_ok && n_shadow[r_ch[ADDR_W-1:0]];
            r_rsp.channel_delayed <= r_ch_ok && active[r_ch[ADDR_W-1:0]];
        end
    end

    assign o_rsp = r_rsp;

endmodule

// File: rtl/ddob_ctrl.sv
module ddob_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_stall,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output ddob_pkg::t_ctrl_cmd  o_cmd
);

    ddob_pkg::t_state r_state;
    ddob_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             slot_free;

    // The result register may be refilled in the same cycle it is taken.
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ddob_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ddob_pkg::ST_READ;
                end
            end
            ddob_pkg::ST_READ: begin
                n_state = ddob_pkg::ST_EXEC;
            end
            ddob_pkg::ST_EXEC: begin
                if (slot_free) begin
                    n_state = ddob_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ddob_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ddob_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ddob_pkg::ST_READ: begin
                o_cmd.read = 1'b1;
            end
            ddob_pkg::ST_EXEC: begin
                o_cmd.commit = slot_free;
            end
            default: begin
            end
        endcase
    end

    assign n_out_valid = o_cmd.commit || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ddob_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/delayed_digital_output_bank.sv
// Bank of CHANNELS digital outputs with on, off and pulse delay timers. Every
// request returns one result carrying the whole output bitmap, the outputs of
// channels without a running delay, and the state of the addressed channel.
// A request passes three steps: capture at acceptance, a registered read of
// the addressed channel's timer storage, then the 32-bit elapsed-time compare
// and state update, which also loads the result register. The next request is
// accepted in the cycle after the update, so the block takes no new request
// before the last one is through its update. A result held by a downstream
// stall does not block the capture of the following request, but it delays
// that request's update step until the result is taken. Check requests walk
// the channels round-robin from channel zero after reset. The pulse length
// register resets to 1000 ms and should be written only while no request is
// in flight.
module delayed_digital_output_bank #(
    parameter int CHANNELS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  ddob_pkg::t_in_req            i_in_req,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output ddob_pkg::t_out_req           o_out_rsp,
    input  logic                         i_cfg_we,
    input  logic [ddob_pkg::TIME_W-1:0]  i_cfg_wdata
);

    ddob_pkg::t_ctrl_cmd cmd;

    ddob_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ddob_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (o_out_rsp)
    );

endmodule

// File: rtl/ddob_checker.sv
`include "delayed_digital_output_bank_macros.svh"

module ddob_checker #(
    parameter int CHANNELS = 8
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ddob_pkg::t_out_req  o_out_rsp
);

    `DDOB_ASSERT_NEXT(a_out_valid_held, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `DDOB_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "request accepted while busy")
    `DDOB_ASSERT_SAME(a_standard_subset, o_out_valid, (o_out_rsp.standard_bits & ~o_out_rsp.output_bits) == '0, "standard bit set on an off output")
    `DDOB_ASSERT_SAME(a_bank_width, o_out_valid, (o_out_rsp.output_bits >> CHANNELS) == '0, "output bit beyond the bank")

endmodule

bind delayed_digital_output_bank ddob_checker #(
    .CHANNELS (CHANNELS)
) u_ddob_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_rsp   (o_out_rsp)
);
